// ----- rtl/lcbs_pkg.sv -----
`default_nettype none
package lcbs_pkg;
    typedef enum logic [2:0] {
        ST_INIT         = 3'd0,
        ST_CONNECT      = 3'd1,
        ST_SETUP_DATA   = 3'd2,
        ST_DATA         = 3'd3,
        ST_SETUP_VERIFY = 3'd4,
        ST_VERIFY       = 3'd5,
        ST_TERMINATE    = 3'd6,
        ST_UNUSED       = 3'd7
    } stage_t;

    localparam logic [1:0] FUNC_FRAME = 2'd0;
    localparam logic [1:0] FUNC_SERIAL = 2'd1;
    localparam logic [1:0] FUNC_TIMER = 2'd2;

    localparam logic [2:0] REG_HANDSHAKE = 3'd0;
    localparam logic [2:0] REG_SIZE = 3'd1;
    localparam logic [2:0] REG_STARTUP_TO = 3'd2;
    localparam logic [2:0] REG_SEND_DELAY = 3'd3;
    localparam logic [2:0] REG_VERIFY_TO = 3'd4;

    typedef struct packed {
        logic step;
        logic div_start;
        logic load_out;
    } lcbs_cmd_t;

    typedef struct packed {
        logic div_done;
    } lcbs_status_t;
endpackage
`default_nettype wire

// ----- rtl/lcbs_ctrl.sv -----
`default_nettype none
module lcbs_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output lcbs_pkg::lcbs_cmd_t        cmd,
    input  wire lcbs_pkg::lcbs_status_t status
);
    import lcbs_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_DIV  = 4'b0010,
        C_WAIT = 4'b0100,
        C_OUT  = 4'b1000
    } cstate_t;

    cstate_t state_reg, state_next;
    logic    ovalid_reg, ovalid_next;

    assign in_stall = (state_reg != C_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        ovalid_next = ovalid_reg;
        cmd = '0;
        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.step = 1'b1;
                    state_next = C_DIV;
                end
            end
            C_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next = C_WAIT;
            end
            C_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = C_OUT;
                end
            end
            C_OUT:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    ovalid_next = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/lcbs_div.sv -----
`default_nettype none
module lcbs_div
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [23:0] dividend,
    input  wire logic [16:0] divisor,
    output logic             done,
    output logic [7:0]       quotient
);
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [23:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [17:0] trial;

    assign done = !busy_reg;
    assign quotient = q_reg[7:0];

    always_comb
    begin
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        q_next = q_reg;
        r_next = r_reg;
        trial = {r_reg, q_reg[23]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 5'd24;
            q_next = dividend;
            r_next = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                r_next = 17'(trial - {1'b0, divisor});
                q_next = {q_reg[22:0], 1'b1};
            end
            else
            begin
                r_next = trial[16:0];
                q_next = {q_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end
endmodule
`default_nettype wire

// ----- rtl/lcbs_dp.sv -----
`default_nettype none
module lcbs_dp
#(
    parameter int LINK_SLOTS = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lcbs_pkg::lcbs_cmd_t   cmd,
    output lcbs_pkg::lcbs_status_t     status,
    input  wire logic                  cfg_valid,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    input  wire logic [1:0]            func,
    input  wire logic                  parent_ready,
    input  wire logic [1:0]            link_id,
    input  wire logic [15:0]           recv_slot0,
    input  wire logic [15:0]           recv_slot1,
    input  wire logic [15:0]           recv_slot2,
    input  wire logic [15:0]           recv_slot3,
    input  wire logic [31:0]           data_word,
    output logic                       send_valid,
    output logic [31:0]                send_word,
    output logic                       start_transfer,
    output logic                       timer_restart,
    output logic [1:0]                 serial_mode,
    output logic [16:0]                word_index,
    output logic [1:0]                 data_stage,
    output logic [1:0]                 verify_result,
    output logic [1:0]                 error_code,
    output logic [7:0]                 progress_pct
);
    import lcbs_pkg::*;

    logic [15:0] hs_code_reg;
    logic [17:0] size_reg;
    logic [7:0]  su_to_reg, delay_reg, ver_to_reg;

    stage_t      stage_reg, stage_next;
    logic [1:0]  phase_reg, phase_next, ver_reg, ver_next, err_reg, err_next;
    logic        parent_reg, parent_next;
    logic [7:0]  sf_reg, sf_next, df_reg, df_next;
    logic [2:0]  uc_reg, uc_next;
    logic [1:0]  slot_reg, slot_next;
    logic [16:0] cur_reg, cur_next, wc_reg, wc_next;
    logic [31:0] sum_reg, sum_next;
    logic [1:0]  mode_reg, mode_next;

    logic        sv_reg, sv_next, st_reg, st_next, tr_reg, tr_next;
    logic [31:0] sw_reg, sw_next;

    logic [15:0] recv [4];
    logic [2:0]  seen, stray;
    logic [2:0]  acked;
    logic        vdone;
    logic [17:0] lim;
    logic [7:0]  quot;
    logic        div_done;

    assign recv[0] = recv_slot0;
    assign recv[1] = recv_slot1;
    assign recv[2] = recv_slot2;
    assign recv[3] = recv_slot3;

    always_comb
    begin
        stage_next = stage_reg; phase_next = phase_reg; ver_next = ver_reg;
        err_next = err_reg; parent_next = parent_reg; sf_next = sf_reg;
        df_next = df_reg; uc_next = uc_reg; slot_next = slot_reg;
        cur_next = cur_reg; wc_next = wc_reg; sum_next = sum_reg;
        mode_next = mode_reg;
        sv_next = 1'b0; sw_next = '0; st_next = 1'b0; tr_next = 1'b0;
        seen = '0; stray = '0; acked = 3'd1; vdone = 1'b0;
        lim = {1'b0, wc_reg} + {15'd0, uc_reg};
        for (int i = 0; i < 4; i++)
        begin
            if (i < LINK_SLOTS)
            begin
                if (recv[i] == hs_code_reg)
                    seen = seen + 3'd1;
                else if (recv[i] != 16'hFFFF)
                    stray = stray + 3'd1;
            end
        end
        if (func == FUNC_FRAME)
        begin
            unique case (stage_reg)
                ST_INIT:
                begin
                    df_next = '0; sf_next = '0; uc_next = '0; slot_next = '0;
                    ver_next = '0; err_next = '0; parent_next = 1'b0;
                    cur_next = '0; wc_next = '0; sum_next = '0;
                    mode_next = 2'd1; phase_next = 2'd1; stage_next = ST_CONNECT;
                end
                ST_CONNECT:
                begin
                    parent_next = parent_ready;
                    st_next = parent_ready;
                    if (err_reg != 2'd0) stage_next = ST_TERMINATE;
                    sf_next = (sf_reg == 8'hFF) ? sf_reg : sf_reg + 8'd1;
                    if (sf_next > su_to_reg)
                    begin
                        err_next = 2'd1;
                        stage_next = ST_TERMINATE;
                    end
                end
                ST_SETUP_DATA, ST_DATA:
                begin
                    if (stage_reg == ST_SETUP_DATA)
                    begin
                        mode_next = 2'd2; sv_next = 1'b1;
                        sw_next = {14'd0, size_reg};
                        wc_next = {1'b0, size_reg[17:2]} + 17'd1;
                        stage_next = ST_DATA;
                    end
                    if (phase_reg != 2'd2)
                    begin
                        if (parent_reg)
                            df_next = (df_reg == 8'hFF) ? df_reg : df_reg + 8'd1;
                        st_next = 1'b1;
                        phase_next = 2'd2;
                    end
                end
                ST_SETUP_VERIFY:
                begin
                    mode_next = 2'd1; stage_next = ST_VERIFY;
                end
                ST_VERIFY:
                begin
                    st_next = parent_reg && (df_reg >= delay_reg);
                    df_next = (df_reg == 8'hFF) ? df_reg : df_reg + 8'd1;
                    if (df_next > ver_to_reg)
                    begin
                        err_next = 2'd3; stage_next = ST_TERMINATE;
                    end
                end
                ST_TERMINATE:
                begin
                    if (phase_reg != 2'd0)
                    begin
                        mode_next = 2'd0; phase_next = 2'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (func == FUNC_SERIAL)
        begin
            if (stage_reg == ST_CONNECT)
            begin
                sv_next = 1'b1; sw_next = {16'd0, hs_code_reg};
                uc_next = seen; slot_next = link_id;
                if (seen <= 3'd2)
                begin
                    if (seen == 3'd2 && stray == 3'd0) stage_next = ST_SETUP_DATA;
                end
                else
                    err_next = 2'd2;
            end
            else if (stage_reg == ST_DATA)
            begin
                sv_next = 1'b1;
                if (cur_reg < wc_reg)
                begin
                    sw_next = data_word; sum_next = sum_reg + data_word;
                end
                else if (cur_reg == wc_reg)
                    sw_next = sum_reg;
                cur_next = cur_reg + 17'd1;
                if ({1'b0, cur_next} < lim)
                    tr_next = 1'b1;
                else
                begin
                    stage_next = ST_SETUP_VERIFY; df_next = '0;
                end
            end
            else if (stage_reg == ST_VERIFY)
            begin
                for (int i = 1; i < 4; i++)
                begin
                    if (!vdone && 3'(i) < uc_reg)
                    begin
                        if (recv[i] == 16'd1)
                            acked = acked + 3'd1;
                        else if (recv[i] == 16'd2)
                        begin
                            ver_next = 2'd2; stage_next = ST_TERMINATE; vdone = 1'b1;
                        end
                        if (!vdone && acked == uc_reg)
                        begin
                            ver_next = 2'd1; stage_next = ST_TERMINATE;
                        end
                    end
                end
            end
        end
        else if (func == FUNC_TIMER)
            st_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_code_reg <= '0; size_reg <= '0;
            su_to_reg <= 8'd30; delay_reg <= 8'd10; ver_to_reg <= 8'd30;
            stage_reg <= ST_INIT; phase_reg <= '0; ver_reg <= '0; err_reg <= '0;
            parent_reg <= 1'b0; sf_reg <= '0; df_reg <= '0; uc_reg <= '0;
            slot_reg <= '0; cur_reg <= '0; wc_reg <= '0; sum_reg <= '0;
            mode_reg <= '0;
            sv_reg <= 1'b0; st_reg <= 1'b0; tr_reg <= 1'b0; sw_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_HANDSHAKE: hs_code_reg <= cfg_data[15:0];
                    REG_SIZE: size_reg <= cfg_data[17:0];
                    REG_STARTUP_TO: su_to_reg <= cfg_data[7:0];
                    REG_SEND_DELAY: delay_reg <= cfg_data[7:0];
                    REG_VERIFY_TO: ver_to_reg <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.step)
            begin
                stage_reg <= stage_next; phase_reg <= phase_next; ver_reg <= ver_next;
                err_reg <= err_next; parent_reg <= parent_next; sf_reg <= sf_next;
                df_reg <= df_next; uc_reg <= uc_next; slot_reg <= slot_next;
                cur_reg <= cur_next; wc_reg <= wc_next; sum_reg <= sum_next;
                mode_reg <= mode_next;
                sv_reg <= sv_next; st_reg <= st_next; tr_reg <= tr_next;
                sw_reg <= sw_next;
            end
        end
    end

    lcbs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({1'b0, cur_reg, 6'd0} + {2'd0, cur_reg, 5'd0} + {5'd0, cur_reg, 2'd0}),
        .divisor  (wc_reg),
        .done     (div_done),
        .quotient (quot)
    );

    assign status.div_done = div_done;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            send_valid <= sv_reg; send_word <= sw_reg;
            start_transfer <= st_reg; timer_restart <= tr_reg;
            serial_mode <= mode_reg; word_index <= cur_reg;
            data_stage <= phase_reg; verify_result <= ver_reg;
            error_code <= err_reg;
            progress_pct <= (wc_reg == 17'd0) ? 8'd0 : quot;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/link_cable_block_sender_core.sv -----
// Channel | Handshake          | Payload
// in      | in_valid/in_stall  | func, parent_ready, link_id, recv_slot0..3, data_word
// out     | out_valid/out_stall| send_valid .. progress_pct
// cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
// States per item: IDLE, DIV, WAIT on the 24-step progress divider, then OUT.
// Input is stalled while an item is in flight.
// Reset loads the default timeouts and clears state, but not the result fields.
// The result register holds while out_valid and out_stall are both high.
`default_nettype none
module link_cable_block_sender_core
#(
    parameter int LINK_SLOTS = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic        parent_ready,
    input  wire logic [1:0]  link_id,
    input  wire logic [15:0] recv_slot0,
    input  wire logic [15:0] recv_slot1,
    input  wire logic [15:0] recv_slot2,
    input  wire logic [15:0] recv_slot3,
    input  wire logic [31:0] data_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             send_valid,
    output logic [31:0]      send_word,
    output logic             start_transfer,
    output logic             timer_restart,
    output logic [1:0]       serial_mode,
    output logic [16:0]      word_index,
    output logic [1:0]       data_stage,
    output logic [1:0]       verify_result,
    output logic [1:0]       error_code,
    output logic [7:0]       progress_pct,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import lcbs_pkg::*;

    lcbs_cmd_t    cmd;
    lcbs_status_t status;

    assign cfg_ready = 1'b1;

    lcbs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    lcbs_dp #(.LINK_SLOTS(LINK_SLOTS)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (func),
        .parent_ready   (parent_ready),
        .link_id        (link_id),
        .recv_slot0     (recv_slot0),
        .recv_slot1     (recv_slot1),
        .recv_slot2     (recv_slot2),
        .recv_slot3     (recv_slot3),
        .data_word      (data_word),
        .send_valid     (send_valid),
        .send_word      (send_word),
        .start_transfer (start_transfer),
        .timer_restart  (timer_restart),
        .serial_mode    (serial_mode),
        .word_index     (word_index),
        .data_stage     (data_stage),
        .verify_result  (verify_result),
        .error_code     (error_code),
        .progress_pct   (progress_pct)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> in_stall) else $error("accept while busy");
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid) else $error("result lost");
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire
